[sv/eip_pkg.sv]
// ----------------------------------------------------------------------------
// eip_pkg
// Shared types, codes and constant functions of the importance pyramid.
// ----------------------------------------------------------------------------
package eip_pkg;

  // Default widest map width
  localparam int unsigned MaxWidthDef = 256;

  localparam int unsigned LumW  = 18;
  localparam int unsigned SinW  = 16;
  localparam int unsigned ChanW = 36;
  localparam int unsigned AccW  = ChanW + 2;

  // Function codes
  localparam logic [1:0] FnLoad  = 2'd0;
  localparam logic [1:0] FnBuild = 2'd1;
  localparam logic [1:0] FnRead  = 2'd2;

  // Status codes
  localparam logic [1:0] StsOk    = 2'd0;
  localparam logic [1:0] StsRange = 2'd1;
  localparam logic [1:0] StsEarly = 2'd2;

  // pi in Q4.60
  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [2:0]  level;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ChanW-1:0] chan0;
    logic [ChanW-1:0] chan1;
    logic [ChanW-1:0] chan2;
    logic [ChanW-1:0] chan3;
  } out_t;

  // Control that travels with each operand into the accumulator
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic mul;
    logic zero;
  } mac_tag_t;

  // Q60 product, elaboration only
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Unsigned quotient by shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(65536 * sin(pi * (2r+1) / 2^w)) by Taylor series, elaboration only
  function automatic logic [15:0] sine_q16(int unsigned r, int unsigned w);
    logic [63:0]  n;
    logic [63:0]  full;
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [63:0]  dv;
    logic [63:0]  s;
    logic [127:0] rn;
    n    = 64'(2 * r + 1);
    full = 64'd1 << w;
    if (n > (full >> 1)) begin
      n = full - n;
    end
    q   = PiQ60 >> w;
    rem = PiQ60 & (full - 64'd1);
    rn  = {64'd0, rem} * {64'd0, n};
    x   = q * n + 64'(rn >> w);
    x2  = mul_q60(x, x);
    sum  = x;
    term = x;
    for (int unsigned k = 1; k <= 12; k++) begin
      dv   = 64'((2 * k) * (2 * k + 1));
      term = udiv64(mul_q60(term, x2), dv);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    s = sum >> 44;
    return (s > 64'd65535) ? 16'hFFFF : s[15:0];
  endfunction

endpackage

[sv/eip_mac.sv]
// ----------------------------------------------------------------------------
// eip_mac
// Shared multiply-accumulate unit: sums four operands per channel and
// returns the quarter of the sum.
// ----------------------------------------------------------------------------
module eip_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  eip_pkg::mac_tag_t            tag_i,
  input  logic [eip_pkg::LumW-1:0]     lum_i,
  input  logic [eip_pkg::SinW-1:0]     sin_i,
  input  logic [eip_pkg::ChanW-1:0]    tex_i,
  output logic                         done_o,
  output logic [eip_pkg::ChanW-1:0]    res_o
);

  eip_pkg::mac_tag_t              tag_q;
  logic [eip_pkg::ChanW-1:0]      opnd_q;
  logic [eip_pkg::ChanW-1:0]      opnd_d;
  logic [eip_pkg::AccW-1:0]       acc_q;
  logic                           done_q;

  // Select the operand: weighted luminance, child channel or zero
  always_comb begin
    if (tag_i.zero) begin
      opnd_d = '0;
    end else if (tag_i.mul) begin
      opnd_d = eip_pkg::ChanW'(lum_i * sin_i);
    end else begin
      opnd_d = tex_i;
    end
  end

  // Register the operand, then accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      done_q <= 1'b0;
    end else begin
      tag_q  <= tag_i;
      done_q <= tag_q.vld && tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    if (tag_q.vld) begin
      if (tag_q.first) begin
        acc_q <= eip_pkg::AccW'(opnd_q);
      end else begin
        acc_q <= acc_q + eip_pkg::AccW'(opnd_q);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q[eip_pkg::AccW-1:2];

endmodule

[sv/envmap_importance_pyramid.sv]
// ----------------------------------------------------------------------------
// envmap_importance_pyramid
// Importance-sampling pyramid for a lat/long environment map: pixel loads,
// a pyramid build through one shared multiply-accumulate unit, texel reads.
// ----------------------------------------------------------------------------
//  channel | signals                          | transfer
//  --------+----------------------------------+------------------------------
//  cfg     | cfg_we_i, cfg_wdata_i            | write when cfg_we_i high
//  in      | in_valid_i, in_ready_o, in_data_i| valid and ready high
//  out     | out_valid_o, out_ready_i, out_data_o | valid and ready high
//
// Loads and unknown codes are answered from StIdle. A read of level L sums
// the sizes of the finer levels in StGeo, then reads the four channels in StRd
// on the single texel memory port. A build works level by level, each one
// followed by StDrain, paced by the one read port of each memory and the shared
// multiply-accumulate unit. One item is in work at a time; in_ready_o is low
// until its result is in the output register, and while that register holds
// a result the receiver has not taken. Reset clears control only; the
// stores hold garbage until written.
module envmap_importance_pyramid #(
  parameter int unsigned MaxWidth = eip_pkg::MaxWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  eip_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output eip_pkg::out_t out_data_o
);

  localparam int unsigned Log2     = $clog2(MaxWidth);
  localparam int unsigned CW       = Log2 - 1;
  localparam int unsigned YW       = Log2 - 1;
  localparam int unsigned LaW      = 2 * Log2 - 1;
  localparam int unsigned LumDepth = MaxWidth * MaxWidth / 2;
  localparam int unsigned TexDepth = MaxWidth * MaxWidth / 6 + 64;
  localparam int unsigned TaW      = $clog2(TexDepth);
  localparam int unsigned TiW      = TaW - 2;
  localparam int unsigned SinDepth = (1 << Log2) - 4;
  localparam int unsigned SiW      = (SinDepth > 1) ? $clog2(SinDepth) : 1;
  localparam int unsigned DrainCyc = 5;

  typedef logic [eip_pkg::SinW-1:0] sin_rom_t [SinDepth];

  // Sine table for every map width, row by row, smallest width first
  function automatic sin_rom_t gen_sin_rom();
    sin_rom_t    t;
    int unsigned base;
    t = '{default: '0};
    for (int unsigned w = 3; w <= Log2; w++) begin
      base = (1 << (w - 1)) - 4;
      for (int unsigned r = 0; r < (1 << (w - 1)); r++) begin
        t[base + r] = eip_pkg::sine_q16(r, w);
      end
    end
    return t;
  endfunction

  localparam sin_rom_t SinRom = gen_sin_rom();

  typedef enum logic [2:0] {
    StIdle,
    StLvl,
    StDrain,
    StGeo,
    StRd
  } state_e;

  state_e                     state_q, state_d;
  logic [3:0]                 wlog_q, wlog_d;
  logic                       built_q, built_d;
  logic                       out_valid_q, out_valid_d;
  eip_pkg::out_t              out_q, out_d;
  logic [3:0]                 lvl_q, lvl_d;
  logic [CW-1:0]              i_q, i_d, j_q, j_d;
  logic [1:0]                 c_q, c_d, p_q, p_d;
  logic [TiW-1:0]             cur_off_q, cur_off_d, poff_q, poff_d;
  logic [TaW-1:0]             ent_ptr_q;
  logic [2:0]                 cnt_q, cnt_d;
  logic [3:0]                 k_q, k_d;
  logic [TiW-1:0]             off_q, off_d;
  logic [7:0]                 rcol_q, rcol_d;
  logic [6:0]                 rrow_q, rrow_d;
  logic [3:0]                 rlvl_q, rlvl_d;
  logic [eip_pkg::ChanW-1:0]  rch_q [4];
  eip_pkg::mac_tag_t          tag_a, tag_b_q;

  logic [3:0]                 w_eff;
  logic                       lvl_last;
  logic [3:0]                 wd_log, ht_log;
  logic [CW-1:0]              imax, jmax;
  logic [YW-1:0]              y;
  logic [Log2-1:0]            x;
  logic [TiW-1:0]             child;
  logic [SiW:0]               soff;
  logic                       accept;
  logic                       lum_we;
  logic [LaW-1:0]             lum_waddr, lum_raddr, load_addr;
  logic [eip_pkg::LumW-1:0]   lum_wdata;
  logic [TaW-1:0]             tex_raddr;
  logic [SiW-1:0]             sin_raddr;
  logic [eip_pkg::LumW-1:0]   lum_mem [LumDepth];
  logic [eip_pkg::ChanW-1:0]  tex_mem [TexDepth];
  logic [eip_pkg::LumW-1:0]   lum_rd_q;
  logic [eip_pkg::ChanW-1:0]  tex_rd_q;
  logic [eip_pkg::SinW-1:0]   sin_rd_q;
  logic                       mac_done;
  logic [eip_pkg::ChanW-1:0]  mac_res;
  logic                       load_ok, rd_ok;
  logic [3:0]                 rwd_log, in_lvl;
  logic [4:0]                 geo_sh;
  logic [TiW-1:0]             rd_base;

  // Clamp the map width
  always_comb begin
    if (wlog_q < 4'd3) begin
      w_eff = 4'd3;
    end else if (wlog_q > 4'(Log2)) begin
      w_eff = 4'(Log2);
    end else begin
      w_eff = wlog_q;
    end
  end

  // Geometry of the level under build
  assign lvl_last = (lvl_q == w_eff - 4'd1);
  assign wd_log   = w_eff - 4'd1 - lvl_q;
  assign ht_log   = lvl_last ? 4'd0 : (w_eff - 4'd2 - lvl_q);
  assign imax     = CW'(((CW + 1)'(1) << wd_log) - (CW + 1)'(1));
  assign jmax     = CW'(((CW + 1)'(1) << ht_log) - (CW + 1)'(1));
  assign y        = YW'({j_q, c_q[1], p_q[1]});
  assign x        = Log2'({i_q, c_q[0], p_q[0]});
  assign child    = poff_q + (TiW'({j_q, c_q[1]}) << (w_eff - lvl_q))
                  + TiW'({i_q, c_q[0]});
  assign soff     = ((SiW + 1)'(1) << (w_eff - 4'd1)) - (SiW + 1)'(4);

  // Input checks
  assign accept    = in_valid_i && in_ready_o;
  assign load_ok   = ((in_data_i.col >> w_eff) == 8'd0)
                  && ((in_data_i.row >> (w_eff - 4'd1)) == 7'd0);
  assign load_addr = (LaW'(in_data_i.row) << w_eff) | LaW'(in_data_i.col);
  assign in_lvl    = {1'b0, in_data_i.level};
  assign rwd_log   = w_eff - 4'd1 - in_lvl;
  always_comb begin
    rd_ok = (in_lvl != 4'd0) && (in_lvl <= w_eff - 4'd1)
         && ((in_data_i.col >> rwd_log) == 8'd0);
    if (in_lvl == w_eff - 4'd1) begin
      rd_ok = rd_ok && (in_data_i.row == 7'd0);
    end else begin
      rd_ok = rd_ok && ((in_data_i.row >> (w_eff - 4'd2 - in_lvl)) == 7'd0);
    end
  end

  // Offset step and texel base of a read
  assign geo_sh  = {w_eff, 1'b0} - 5'd3 - {k_q, 1'b0};
  assign rd_base = off_q + (TiW'(rrow_q) << (w_eff - 4'd1 - rlvl_q)) + TiW'(rcol_q);

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wlog_d      = wlog_q;
    built_d     = built_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    lvl_d       = lvl_q;
    i_d         = i_q;
    j_d         = j_q;
    c_d         = c_q;
    p_d         = p_q;
    cur_off_d   = cur_off_q;
    poff_d      = poff_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    off_d       = off_q;
    rcol_d      = rcol_q;
    rrow_d      = rrow_q;
    rlvl_d      = rlvl_q;
    tag_a       = '0;
    lum_we      = 1'b0;
    lum_waddr   = load_addr;
    lum_wdata   = eip_pkg::LumW'(in_data_i.red) + eip_pkg::LumW'(in_data_i.green)
                + eip_pkg::LumW'(in_data_i.blue);
    lum_raddr   = (LaW'(y) << w_eff) | LaW'(x);
    sin_raddr   = SiW'(soff) + SiW'(y);
    tex_raddr   = {child, p_q};

    if (cfg_we_i) begin
      wlog_d  = cfg_wdata_i;
      built_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          out_d = '0;
          unique case (in_data_i.func)
            eip_pkg::FnLoad: begin
              out_valid_d = 1'b1;
              if (load_ok) begin
                lum_we = 1'b1;
              end else begin
                out_d.status = eip_pkg::StsRange;
              end
            end
            eip_pkg::FnBuild: begin
              lvl_d     = 4'd1;
              i_d       = '0;
              j_d       = '0;
              c_d       = '0;
              p_d       = '0;
              cur_off_d = '0;
              poff_d    = '0;
              state_d   = StLvl;
            end
            eip_pkg::FnRead: begin
              if (!built_q) begin
                out_d.status = eip_pkg::StsEarly;
                out_valid_d  = 1'b1;
              end else if (!rd_ok) begin
                out_d.status = eip_pkg::StsRange;
                out_valid_d  = 1'b1;
              end else begin
                rcol_d  = in_data_i.col;
                rrow_d  = in_data_i.row;
                rlvl_d  = in_lvl;
                k_d     = 4'd1;
                off_d   = '0;
                state_d = StGeo;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      // Issue one operand per cycle: p, then channel, column, row
      StLvl: begin
        tag_a.vld   = 1'b1;
        tag_a.first = (p_q == 2'd0);
        tag_a.last  = (p_q == 2'd3);
        tag_a.mul   = (lvl_q == 4'd1);
        tag_a.zero  = lvl_last && c_q[1];
        p_d = p_q + 2'd1;
        if (p_q == 2'd3) begin
          c_d = c_q + 2'd1;
          if (c_q == 2'd3) begin
            i_d = (i_q == imax) ? '0 : i_q + CW'(1);
            if (i_q == imax) begin
              j_d = j_q + CW'(1);
              if (j_q == jmax) begin
                cnt_d   = '0;
                state_d = StDrain;
              end
            end
          end
        end
      end

      // Let the last writes of the level land, then advance
      StDrain: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(DrainCyc - 1)) begin
          if (lvl_last) begin
            built_d      = 1'b1;
            out_d        = '0;
            out_valid_d  = 1'b1;
            state_d      = StIdle;
          end else begin
            poff_d    = cur_off_q;
            cur_off_d = cur_off_q + (TiW'(1) << (wd_log + ht_log));
            lvl_d     = lvl_q + 4'd1;
            i_d       = '0;
            j_d       = '0;
            c_d       = '0;
            p_d       = '0;
            state_d   = StLvl;
          end
        end
      end

      // Sum the sizes of the finer levels
      StGeo: begin
        if (k_q == rlvl_q) begin
          cnt_d   = '0;
          state_d = StRd;
        end else begin
          off_d = off_q + (TiW'(1) << geo_sh);
          k_d   = k_q + 4'd1;
        end
      end

      // Read the four channels
      StRd: begin
        tex_raddr = {rd_base, cnt_q[1:0]};
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          out_d.status = eip_pkg::StsOk;
          out_d.chan0  = rch_q[0];
          out_d.chan1  = rch_q[1];
          out_d.chan2  = rch_q[2];
          out_d.chan3  = tex_rd_q;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wlog_q      <= 4'd8;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      tag_b_q     <= '0;
      ent_ptr_q   <= '0;
    end else begin
      state_q     <= state_d;
      wlog_q      <= wlog_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      tag_b_q     <= tag_a;
      if (state_q == StIdle) begin
        ent_ptr_q <= '0;
      end else if (mac_done) begin
        ent_ptr_q <= ent_ptr_q + TaW'(1);
      end
    end
  end

  // Payload and counters
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    lvl_q     <= lvl_d;
    i_q       <= i_d;
    j_q       <= j_d;
    c_q       <= c_d;
    p_q       <= p_d;
    cur_off_q <= cur_off_d;
    poff_q    <= poff_d;
    cnt_q     <= cnt_d;
    k_q       <= k_d;
    off_q     <= off_d;
    rcol_q    <= rcol_d;
    rrow_q    <= rrow_d;
    rlvl_q    <= rlvl_d;
    if (state_q == StRd && cnt_q != 3'd0 && cnt_q != 3'd4) begin
      rch_q[cnt_q[1:0] - 2'd1] <= tex_rd_q;
    end
  end

  // Luminance store
  always_ff @(posedge clk_i) begin
    if (lum_we) begin
      lum_mem[lum_waddr] <= lum_wdata;
    end
    lum_rd_q <= lum_mem[lum_raddr];
  end

  // Texel store
  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      tex_mem[ent_ptr_q] <= mac_res;
    end
    tex_rd_q <= tex_mem[tex_raddr];
  end

  // Sine table
  always_ff @(posedge clk_i) begin
    sin_rd_q <= SinRom[sin_raddr];
  end

  eip_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_b_q),
    .lum_i  (lum_rd_q),
    .sin_i  (sin_rd_q),
    .tex_i  (tex_rd_q),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_busy_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("input taken while busy");

  a_fail_no_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != eip_pkg::StsOk) |->
      (out_data_o.chan0 == '0 && out_data_o.chan1 == '0 &&
       out_data_o.chan2 == '0 && out_data_o.chan3 == '0))
    else $error("failed item carries texel data");

  a_mac_in_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == StLvl || state_q == StDrain))
    else $error("texel write outside build");
`endif

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for envmap_importance_pyramid. Pixel maps are loaded in
// full at the two smallest widths, one of them reached through the low clamp
// of the width register. Each map is built, then read back at random over all
// levels, with noise and out-of-range items mixed in. The high clamp is
// probed with loads and reads before any build. A scoreboard keeps its own
// copy of the luminance and texel stores and compares every result transfer
// field by field. Sender gaps and receiver stalls vary by phase, and one long
// receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FnNone    = 2'd3;
  localparam int         LimitCyc  = 3000000;
  localparam int         LumDepth  = 32768;
  localparam int         TexDepth  = 44000;

  // Scoreboard: mirrors the stores and predicts each result
  class pyramid_scoreboard;
    int              map_log2;
    bit              built;
    bit [17:0]       lum[];
    bit [35:0]       tex[];
    eip_pkg::out_t   texel_q[$];
    int              errors;
    int              n_load, n_build, n_read, n_checked;

    function new();
      lum      = new[LumDepth];
      tex      = new[TexDepth];
      map_log2 = 8;
      built    = 0;
    endfunction

    function void set_width(bit [3:0] v);
      map_log2 = (v < 3) ? 3 : ((v > 8) ? 8 : int'(v));
      built    = 0;
    endfunction

    function bit [63:0] fx_mul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
    endfunction

    function void level_dims(int l, output int wd, output int ht, output int off);
      int kw, kh;
      off = 0;
      wd  = 0;
      ht  = 0;
      for (int k = 1; k <= l; k++) begin
        kw = 1 << (map_log2 - 1 - k);
        kh = (k == map_log2 - 1) ? 1 : (1 << (map_log2 - 2 - k));
        if (k == l) begin
          wd = kw;
          ht = kh;
          return;
        end
        off += kw * kh;
      end
    endfunction

    // Recompute every level from the luminance store
    function void build_pyramid();
      bit [15:0] srow[128];
      bit [63:0] n, full, q, rem, x, x2, sum, term, acc;
      int        w, hgt, wd, ht, off, pwd, pht, poff, y, xx, child;
      w    = 1 << map_log2;
      hgt  = w / 2;
      full = 64'd1 << map_log2;
      for (int r = 0; r < hgt; r++) begin
        n = 64'(2 * r + 1);
        if (n > full / 2) n = full - n;
        q    = eip_pkg::PiQ60 >> map_log2;
        rem  = eip_pkg::PiQ60 & (full - 1);
        x    = q * n + ((rem * n) >> map_log2);
        x2   = fx_mul(x, x);
        sum  = x;
        term = x;
        for (int k = 1; k <= 12; k++) begin
          term = fx_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        sum     = sum >> 44;
        srow[r] = (sum > 64'd65535) ? 16'hFFFF : sum[15:0];
      end
      level_dims(1, wd, ht, off);
      for (int j = 0; j < ht; j++)
        for (int i = 0; i < wd; i++)
          for (int c = 0; c < 4; c++) begin
            acc = 0;
            for (int p = 0; p < 4; p++) begin
              y   = 4 * j + 2 * (c >> 1) + (p >> 1);
              xx  = 4 * i + 2 * (c & 1) + (p & 1);
              acc += 64'(lum[y * w + xx]) * 64'(srow[y]);
            end
            tex[4 * (off + j * wd + i) + c] = 36'(acc >> 2);
          end
      for (int l = 2; l <= map_log2 - 1; l++) begin
        pwd  = wd;
        poff = off;
        level_dims(l, wd, ht, off);
        for (int j = 0; j < ht; j++)
          for (int i = 0; i < wd; i++)
            for (int c = 0; c < 4; c++) begin
              acc = 0;
              // top level keeps only its upper quadrants
              if (!(l == map_log2 - 1 && (c >> 1) != 0)) begin
                child = poff + (2 * j + (c >> 1)) * pwd + 2 * i + (c & 1);
                for (int k = 0; k < 4; k++) acc += 64'(tex[4 * child + k]);
                acc = acc >> 2;
              end
              tex[4 * (off + j * wd + i) + c] = 36'(acc);
            end
      end
      built = 1;
    endfunction

    // Note an accepted input transfer and queue its expected result
    function void note_item(eip_pkg::in_t it);
      eip_pkg::out_t e;
      int            w, wd, ht, off, base;
      e = '0;
      w = 1 << map_log2;
      case (it.func)
        eip_pkg::FnLoad: begin
          n_load++;
          if (it.col < w && it.row < w / 2)
            lum[it.row * w + it.col] = 18'(it.red) + 18'(it.green) + 18'(it.blue);
          else e.status = eip_pkg::StsRange;
        end
        eip_pkg::FnBuild: begin
          n_build++;
          build_pyramid();
        end
        eip_pkg::FnRead: begin
          n_read++;
          if (!built) e.status = eip_pkg::StsEarly;
          else if (it.level < 1 || it.level > map_log2 - 1) e.status = eip_pkg::StsRange;
          else begin
            level_dims(int'(it.level), wd, ht, off);
            if (it.col >= wd || it.row >= ht) e.status = eip_pkg::StsRange;
            else begin
              base    = 4 * (off + it.row * wd + it.col);
              e.chan0 = tex[base];
              e.chan1 = tex[base + 1];
              e.chan2 = tex[base + 2];
              e.chan3 = tex[base + 3];
            end
          end
        end
        default: ;
      endcase
      texel_q.push_back(e);
    endfunction

    // Check a result transfer against the oldest expectation
    function void check(eip_pkg::out_t got);
      eip_pkg::out_t e;
      n_checked++;
      if (texel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      e = texel_q.pop_front();
      if (e.status !== got.status || e.chan0 !== got.chan0 || e.chan1 !== got.chan1 ||
          e.chan2 !== got.chan2 || e.chan3 !== got.chan3) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d mismatch", n_checked);
          $display("  status exp %0d got %0d", e.status, got.status);
          $display("  chan0 exp %h got %h  chan1 exp %h got %h",
                   e.chan0, got.chan0, e.chan1, got.chan1);
          $display("  chan2 exp %h got %h  chan3 exp %h got %h",
                   e.chan2, got.chan2, e.chan3, got.chan3);
        end
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [3:0]    cfg_wdata_i;
  logic          in_valid_i;
  logic          in_ready_o;
  eip_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  eip_pkg::out_t out_data_o;

  pyramid_scoreboard sb = new();
  int cur_log2;
  int idle_mode;
  int hold_left;
  int cycles;

  envmap_importance_pyramid DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watch both channels for transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_item(in_data_i);
      if (out_valid_o && out_ready_i) sb.check(out_data_o);
    end
  end

  // Drive the receiver: hold-off first, then the phase's stall pattern
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready_i <= ($urandom_range(99) >= 67);
    end else if (idle_mode == 3) begin
      out_ready_i <= ($urandom_range(99) >= 9);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCyc) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic eip_pkg::in_t make_item(logic [1:0] f, int c, int r, int l,
                                             int rd, int gr, int bl);
    eip_pkg::in_t it;
    it.func  = f;
    it.col   = 8'(c);
    it.row   = 7'(r);
    it.level = 3'(l);
    it.red   = 16'(rd);
    it.green = 16'(gr);
    it.blue  = 16'(bl);
    return it;
  endfunction

  // Offer one item, with a gap first when the phase calls for it
  task automatic send(eip_pkg::in_t it);
    int p;
    p = $urandom_range(99);
    if ((idle_mode == 1 && p < 67) || (idle_mode == 3 && p < 9)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.texel_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Random noise: unknown codes and loads off the map
  task automatic send_noise();
    if ($urandom_range(1) == 0 || cur_log2 == 8)
      send(make_item(FnNone, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
    else
      send(make_item(eip_pkg::FnLoad, $urandom_range(1 << cur_log2, 255),
                     $urandom_range(127), $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic load_pixel(int c, int r);
    int rd, gr, bl;
    case ($urandom_range(9))
      0: begin rd = 0; gr = 0; bl = 0; end
      1: begin rd = 32'hFFFF; gr = 32'hFFFF; bl = 32'hFFFF; end
      default: begin rd = $urandom; gr = $urandom; bl = $urandom; end
    endcase
    send(make_item(eip_pkg::FnLoad, c, r, $urandom, rd, gr, bl));
  endtask

  // Mostly reads inside the pyramid, some anywhere in the field ranges
  task automatic read_random(int n);
    int l, wd, ht;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 85) begin
        l  = $urandom_range(1, cur_log2 - 1);
        wd = 1 << (cur_log2 - 1 - l);
        ht = (l == cur_log2 - 1) ? 1 : (1 << (cur_log2 - 2 - l));
        send(make_item(eip_pkg::FnRead, $urandom_range(wd - 1), $urandom_range(ht - 1), l,
                       $urandom, $urandom, $urandom));
      end else begin
        send(make_item(eip_pkg::FnRead, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom));
      end
    end
  endtask

  // One width setting: load the whole map, build, read back, rebuild
  task automatic run_phase(logic [3:0] wcfg, int mode, int nreads, bit squeeze);
    int w, top;
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wcfg;
    sb.set_width(wcfg);
    cur_log2 = sb.map_log2;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    idle_mode = mode;
    w   = 1 << cur_log2;
    top = cur_log2 - 1;
    send(make_item(eip_pkg::FnRead, 0, 0, 1, 0, 0, 0));
    for (int r = 0; r < w / 2; r++)
      for (int c = 0; c < w; c++) begin
        if (cur_log2 < 8 && $urandom_range(19) == 0) send_noise();
        load_pixel(c, r);
      end
    send(make_item(eip_pkg::FnBuild, 0, 0, 0, 0, 0, 0));
    // coarsest texel, one level past it, level zero, column just past level 1
    send(make_item(eip_pkg::FnRead, 0, 0, top, 0, 0, 0));
    send(make_item(eip_pkg::FnRead, 0, 0, top + 1, 0, 0, 0));
    send(make_item(eip_pkg::FnRead, 0, 0, 0, 0, 0, 0));
    send(make_item(eip_pkg::FnRead, w / 4, 0, 1, 0, 0, 0));
    if (squeeze) begin
      @(negedge clk_i);
      hold_left = 400;
      @(posedge clk_i);
    end
    read_random(nreads);
    for (int k = 0; k < 10; k++) begin
      load_pixel($urandom_range(w - 1), $urandom_range(w / 2 - 1));
      if ($urandom_range(3) == 0) send_noise();
    end
    send(make_item(eip_pkg::FnBuild, 0, 0, 0, 0, 0, 0));
    read_random(nreads / 4);
  endtask

  // Width register past the top clamp: loads, noise and reads before any build
  task automatic probe_phase(logic [3:0] wcfg, int n);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wcfg;
    sb.set_width(wcfg);
    cur_log2 = sb.map_log2;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    idle_mode = 3;
    for (int k = 0; k < n; k++) begin
      if (k % 3 == 0) begin
        load_pixel($urandom_range(255), $urandom_range(127));
      end else if (k % 3 == 1) begin
        send(make_item(eip_pkg::FnRead, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 4'd0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    idle_mode   = 0;
    hold_left   = 0;
    cycles      = 0;
    cur_log2    = 8;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: read before any build, unknown code with all bits set
    send(make_item(eip_pkg::FnRead, 0, 0, 1, 0, 0, 0));
    send(make_item(FnNone, 255, 127, 7, 32'hFFFF, 32'hFFFF, 32'hFFFF));

    run_phase(4'd0, 0, 40, 1'b0);
    run_phase(4'd4, 1, 40, 1'b0);
    run_phase(4'd3, 2, 60, 1'b0);
    run_phase(4'd4, 3, 60, 1'b1);
    probe_phase(4'd15, 30);

    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d loads, %0d builds and %0d reads on maps 8 and 16 wide,",
             sb.n_load, sb.n_build, sb.n_read);
    $display("plus the width register past both clamps; %0d results checked, %0d mismatches.",
             sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.texel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/eip_pkg.sv
sv/eip_mac.sv
sv/envmap_importance_pyramid.sv
test/tb_top.sv
